FILE: rtl/core/ppgbr_pkg.sv
`timescale 1ns / 1ps
package ppgbr_pkg;

  localparam int SAMPLE_W = 18;
  localparam int TS_W     = 32;
  localparam int LEVEL_W  = 23;
  localparam int AC_W     = 24;
  localparam int RATE_W   = 32;
  localparam int DC_W     = 32;
  localparam int LP_W     = 40;
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_MIN_LEVEL = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_LEVEL = 2'd1;
  localparam logic [IDX_W-1:0] REG_TICKS     = 2'd2;

  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 23'd100;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 23'd2000;
  localparam logic [RATE_W-1:0]  TICKS_RST     = 32'd60000000;

  localparam logic signed [24:0] LP_B = 25'sd4114399;
  localparam logic signed [24:0] LP_A = 25'sd8548419;

  typedef struct packed {
    logic signed [AC_W-1:0] ac_value;
    logic [TS_W-1:0]        timestamp;
  } ppgbr_item_t;

endpackage

FILE: rtl/core/ppgbr_divider.sv
`timescale 1ns / 1ps
module ppgbr_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [38:0] dividend,
  input  logic [38:0] divisor,
  output logic        done,
  output logic [38:0] quotient
);

  logic [38:0] rem_r, rem_nxt;
  logic [38:0] quo_r, quo_nxt;
  logic [38:0] den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [39:0] trial;
  logic [39:0] diff;

  assign trial = {rem_r, quo_r[38]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = 6'd39;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[39]) begin
        rem_nxt = diff[38:0];
        quo_nxt = {quo_r[37:0], 1'b1};
      end else begin
        rem_nxt = trial[38:0];
        quo_nxt = {quo_r[37:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/ppgbr_front.sv
`timescale 1ns / 1ps
module ppgbr_front #(
  parameter int MEAN_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ppgbr_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic [ppgbr_pkg::TS_W-1:0]          in_timestamp,
  output logic                                q_valid,
  input  logic                                q_full,
  output ppgbr_pkg::ppgbr_item_t              q_item,
  output logic                                div_start,
  output logic [38:0]                         div_num,
  output logic [38:0]                         div_den,
  input  logic                                div_done,
  input  logic [38:0]                         div_quo,
  input  logic                                div_grant
);

  localparam int MW  = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
  localparam int FW  = $clog2(MEAN_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DC    = 6'b000010,
    S_MEAN  = 6'b000100,
    S_DIV   = 6'b001000,
    S_LP    = 6'b010000,
    S_OUT   = 6'b100000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic signed [31:0] dc_r, dc_nxt;
  logic signed [31:0] dcx_r;
  logic signed [31:0] mean_mem [MEAN_DEPTH];
  logic signed [31:0] old_rd_r;
  logic signed [31:0] sum_r;
  logic [MW-1:0]      slot_r;
  logic [FW-1:0]      fill_r;
  logic signed [31:0] mean_r;
  logic signed [39:0] lp_prior_r, lp_latest_r;
  logic signed [23:0] ac_r;
  logic [31:0]        ts_r;
  logic [17:0]        smp_r;
  logic signed [39:0] dc_t;
  logic signed [39:0] dc_abs;
  logic               dc_neg;
  logic [31:0]        dcabs_r;
  logic               dcneg_r;
  logic [63:0]        dc_prod;
  logic [31:0]        dc_q;
  logic signed [31:0] sum_new;
  logic               sum_neg;
  logic [31:0]        sum_abs;
  logic signed [31:0] lp_x;
  logic signed [63:0] bx, ap;
  logic signed [63:0] acc;
  logic signed [63:0] lat_w;
  logic signed [40:0] s41;
  logic signed [40:0] s_div;
  logic signed [23:0] sat;
  logic               dc_pend_r;
  logic [1:0]         lp_ph_r;
  logic signed [63:0] bx_r, ap_r;

  assign in_stall = (state_r != S_IDLE);
  assign dc_t     = signed'(40'(smp_r)) * 40'sd100 + 40'(dc_r) * 40'sd94;
  assign dc_neg   = dc_t[39];
  assign dc_abs   = dc_neg ? -dc_t : dc_t;
  assign dc_prod  = 64'(dcabs_r) * 64'd1374389535;
  assign dc_q     = 32'(dc_prod[63:37]);
  assign sum_new  = sum_r - old_rd_r + dcx_r;
  assign sum_neg  = sum_new[31];
  assign sum_abs  = sum_neg ? 32'(-sum_new) : 32'(sum_new);
  assign lp_x     = mean_r - dcx_r;
  assign bx       = 64'(lp_x) * 64'(ppgbr_pkg::LP_B);
  assign ap       = 64'(lp_latest_r) * 64'(ppgbr_pkg::LP_A);
  assign acc      = (bx_r <<< 8) + ap_r + 64'sd8388608;
  assign lat_w    = acc >>> 24;
  assign s41      = 41'(lp_prior_r) + 41'(lp_latest_r);
  assign s_div    = s41[40] ? -((-s41) >>> 8) : (s41 >>> 8);
  assign sat      = (s_div > 41'sd8388607) ? 24'sd8388607 :
                    (s_div < -41'sd8388608) ? -24'sd8388608 : 24'(s_div);

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_DC;
      S_DC:    if (!dc_pend_r) state_nxt = S_MEAN;
      S_MEAN:  if (div_grant) begin
        div_start = 1'b1;
        div_num   = {7'd0, sum_abs};
        div_den   = {{(39-FW){1'b0}}, (fill_r == FW'(MEAN_DEPTH)) ? fill_r : fill_r + FW'(1)};
        state_nxt = S_DIV;
      end
      S_DIV:   if (div_done) state_nxt = S_LP;
      S_LP:    if (lp_ph_r == 2'd2) state_nxt = S_OUT;
      S_OUT:   if (!q_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    dc_nxt = dc_r;
    if (dcneg_r) begin
      dc_nxt = -$signed(dc_q);
    end else begin
      dc_nxt = $signed(dc_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dc_r        <= '0;
      sum_r       <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      lp_prior_r  <= '0;
      lp_latest_r <= '0;
      dc_pend_r   <= 1'b0;
      lp_ph_r     <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (in_valid) begin
          dc_pend_r <= 1'b1;
        end
        S_DC: begin
          if (dc_pend_r) begin
            dcabs_r   <= dc_abs[31:0];
            dcneg_r   <= dc_neg;
            dc_pend_r <= 1'b0;
          end else begin
            dc_r  <= dc_nxt;
            dcx_r <= dc_nxt - dc_r;
          end
        end
        S_MEAN: if (div_grant) begin
          sum_r            <= sum_new;
          mean_mem[slot_r] <= dcx_r;
          slot_r           <= (32'(slot_r) + 1 >= MEAN_DEPTH) ? '0 : slot_r + MW'(1);
          if (fill_r != FW'(MEAN_DEPTH)) fill_r <= fill_r + FW'(1);
        end
        S_DIV: if (div_done) begin
          mean_r  <= sum_r[31] ? -32'(div_quo[31:0]) : 32'(div_quo[31:0]);
          lp_ph_r <= 2'd0;
        end
        S_LP: begin
          lp_ph_r <= lp_ph_r + 2'd1;
          if (lp_ph_r == 2'd0) begin
            bx_r <= bx;
            ap_r <= ap;
          end else if (lp_ph_r == 2'd1) begin
            lp_prior_r  <= lp_latest_r;
            lp_latest_r <= 40'(lat_w);
          end else begin
            ac_r <= sat;
          end
        end
        default: ;
      endcase
    end
    if (state_r == S_IDLE && in_valid) begin
      smp_r    <= in_sample;
      ts_r     <= in_timestamp;
      old_rd_r <= (fill_r == FW'(MEAN_DEPTH)) ? mean_mem[slot_r] : '0;
    end
  end

  assign q_valid          = (state_r == S_OUT) && !q_full;
  assign q_item.ac_value  = ac_r;
  assign q_item.timestamp = ts_r;

endmodule

FILE: rtl/core/ppgbr_back.sv
`timescale 1ns / 1ps
module ppgbr_back #(
  parameter int RATE_DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  ppgbr_pkg::ppgbr_item_t          q_item,
  input  logic [ppgbr_pkg::LEVEL_W-1:0]   min_level,
  input  logic [ppgbr_pkg::LEVEL_W-1:0]   max_level,
  input  logic [ppgbr_pkg::RATE_W-1:0]    ticks,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [ppgbr_pkg::AC_W-1:0] out_ac_value,
  output logic                            out_beat,
  output logic [ppgbr_pkg::RATE_W-1:0]    out_bpm,
  output logic                            div_start,
  output logic [38:0]                     div_num,
  output logic [38:0]                     div_den,
  input  logic                            div_done,
  input  logic [38:0]                     div_quo,
  output logic                            div_busy
);

  localparam int RW = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
  localparam int FW = $clog2(RATE_DEPTH + 1);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_TRK  = 7'b0000010,
    B_RDIV = 7'b0000100,
    B_SUM  = 7'b0001000,
    B_ADIV = 7'b0010000,
    B_OUT  = 7'b0100000,
    B_WAIT = 7'b1000000
  } bstate_t;

  typedef enum logic [1:0] {
    M_IDLE    = 2'd0,
    M_RISING  = 2'd1,
    M_FALLING = 2'd2
  } mode_t;

  bstate_t state_r;
  mode_t   mode_r;
  logic [31:0] hist_r [RATE_DEPTH];
  logic [RW-1:0] slot_r;
  logic [FW-1:0] fill_r;
  logic [RW-1:0] idx_r;
  logic [38:0]   total_r;
  logic [31:0]   avg_r;
  logic [23:0]   prev_r;
  logic [31:0]   peak_r, ppeak_r;
  logic signed [23:0] ac_r;
  logic [31:0]   ts_r;
  logic          beat_r;
  logic [31:0]   span;
  logic [22:0]   v;
  logic          invalid;

  assign span    = peak_r - ppeak_r;
  assign v       = ac_r[22:0];
  assign invalid = ac_r[23] || (v > max_level);
  assign q_pop   = (state_r == B_IDLE) && q_valid;
  assign div_busy = (state_r == B_RDIV) || (state_r == B_ADIV) ||
                    (state_r == B_TRK) || (state_r == B_SUM);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_r == B_TRK && !invalid && mode_r == M_RISING && !(24'(v) > prev_r) &&
        span != 32'd0) begin
      div_start = 1'b1;
      div_num   = {7'd0, ticks};
      div_den   = {7'd0, span};
    end else if (state_r == B_SUM && 32'(idx_r) == RATE_DEPTH - 1) begin
      div_start = 1'b1;
      div_num   = total_r + {7'd0, hist_r[idx_r]};
      div_den   = {{(39-FW){1'b0}},
                   (fill_r == FW'(RATE_DEPTH)) ? fill_r : fill_r + FW'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      mode_r  <= M_IDLE;
      slot_r  <= '0;
      fill_r  <= '0;
      avg_r   <= '0;
      prev_r  <= '0;
      peak_r  <= '0;
      ppeak_r <= '0;
      for (int i = 0; i < RATE_DEPTH; i++) hist_r[i] <= '0;
    end else begin
      case (state_r)
        B_IDLE: if (q_valid) begin
          ac_r    <= q_item.ac_value;
          ts_r    <= q_item.timestamp;
          state_r <= B_TRK;
        end
        B_TRK: begin
          beat_r  <= 1'b0;
          state_r <= B_OUT;
          if (invalid) begin
            mode_r  <= M_IDLE;
            prev_r  <= '0;
            peak_r  <= '0;
            ppeak_r <= '0;
          end else begin
            case (mode_r)
              M_RISING: begin
                if (24'(v) > prev_r) begin
                  peak_r <= ts_r;
                  prev_r <= 24'(v);
                end else begin
                  beat_r  <= 1'b1;
                  ppeak_r <= peak_r;
                  mode_r  <= M_FALLING;
                  if (span != 32'd0) begin
                    state_r <= B_RDIV;
                  end else begin
                    hist_r[slot_r] <= '0;
                    idx_r   <= '0;
                    total_r <= '0;
                    state_r <= B_SUM;
                  end
                end
              end
              M_FALLING: begin
                if (v < min_level) mode_r <= M_IDLE;
                prev_r <= 24'(v);
              end
              default: begin
                if (v >= min_level) mode_r <= M_RISING;
                prev_r <= 24'(v);
              end
            endcase
          end
        end
        B_RDIV: if (div_done) begin
          hist_r[slot_r] <= div_quo[31:0];
          idx_r   <= '0;
          total_r <= '0;
          state_r <= B_SUM;
        end
        B_SUM: begin
          total_r <= total_r + {7'd0, hist_r[idx_r]};
          if (32'(idx_r) == RATE_DEPTH - 1) begin
            slot_r  <= (32'(slot_r) + 1 >= RATE_DEPTH) ? '0 : slot_r + RW'(1);
            state_r <= B_ADIV;
          end else begin
            idx_r <= idx_r + RW'(1);
          end
          if (32'(idx_r) == RATE_DEPTH - 1 && fill_r != FW'(RATE_DEPTH)) begin
            fill_r <= fill_r + FW'(1);
          end
        end
        B_ADIV: if (div_done) begin
          avg_r   <= div_quo[31:0];
          state_r <= B_OUT;
        end
        B_OUT:  state_r <= B_WAIT;
        B_WAIT: if (!out_stall) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid    = (state_r == B_WAIT);
  assign out_ac_value = ac_r;
  assign out_beat     = beat_r;
  assign out_bpm      = avg_r;

endmodule

FILE: rtl/core/ppg_beat_and_rate_detector.sv
`timescale 1ns / 1ps
// A sample that completes a heart beat also uses the shared divider in the back
// for the rate division (when the peak interval is non-zero) and the average.
// The front takes no new sample until it is through with the last one, including
// the 39-step mean division; the front stalls while the back holds the divider or the
// two-entry queue is full.
// Reset (rst_n low, synchronous) clears filter, mean, tracker and rate state.
module ppg_beat_and_rate_detector #(
  parameter int MEAN_DEPTH = 16,
  parameter int RATE_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ppgbr_pkg::SAMPLE_W-1:0]       in_sample,
  input  logic [ppgbr_pkg::TS_W-1:0]           in_timestamp,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ppgbr_pkg::AC_W-1:0]    out_ac_value,
  output logic                                 out_beat,
  output logic [ppgbr_pkg::RATE_W-1:0]         out_bpm,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ppgbr_pkg::IDX_W-1:0]          cfg_index,
  input  logic [31:0]                          cfg_data
);

  logic [ppgbr_pkg::LEVEL_W-1:0] min_r, max_r;
  logic [ppgbr_pkg::RATE_W-1:0]  ticks_r;

  ppgbr_pkg::ppgbr_item_t fq_item, q_mem [2], q_head;
  logic        f_push, q_full, q_empty, q_pop;
  logic [1:0]  q_cnt_r;
  logic        q_wp_r, q_rp_r;

  logic        fs, bs, dd;
  logic [38:0] fn, fd, bn, bd, dn, ddn, dq;
  logic        b_busy, f_own_r, f_run_r;
  logic        dd_grant_f;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= ppgbr_pkg::MIN_LEVEL_RST;
      max_r   <= ppgbr_pkg::MAX_LEVEL_RST;
      ticks_r <= ppgbr_pkg::TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ppgbr_pkg::REG_MIN_LEVEL: min_r   <= cfg_data[ppgbr_pkg::LEVEL_W-1:0];
        ppgbr_pkg::REG_MAX_LEVEL: max_r   <= cfg_data[ppgbr_pkg::LEVEL_W-1:0];
        ppgbr_pkg::REG_TICKS:     ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign q_full  = (q_cnt_r == 2'd2);
  assign q_empty = (q_cnt_r == 2'd0);
  assign q_head  = q_mem[q_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      f_own_r <= 1'b0;
      f_run_r <= 1'b0;
    end else begin
      if (f_push) q_wp_r <= ~q_wp_r;
      if (q_pop)  q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + {1'b0, f_push} - {1'b0, q_pop};
      if (fs) f_own_r <= 1'b1;
      else if (bs) f_own_r <= 1'b0;
      if (fs) f_run_r <= 1'b1;
      else if (dd) f_run_r <= 1'b0;
    end
    if (f_push) q_mem[q_wp_r] <= fq_item;
  end

  assign dd_grant_f = !b_busy && !bs;

  assign dn  = fs ? fn : bn;
  assign ddn = fs ? fd : bd;

  ppgbr_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (fs || bs),
    .dividend (dn),
    .divisor  (ddn),
    .done     (dd),
    .quotient (dq)
  );

  ppgbr_front #(.MEAN_DEPTH(MEAN_DEPTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_timestamp (in_timestamp),
    .q_valid      (f_push),
    .q_full       (q_full),
    .q_item       (fq_item),
    .div_start    (fs),
    .div_num      (fn),
    .div_den      (fd),
    .div_done     (dd && f_own_r),
    .div_quo      (dq),
    .div_grant    (dd_grant_f)
  );

  ppgbr_back #(.RATE_DEPTH(RATE_DEPTH)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (!q_empty && !f_run_r && !fs),
    .q_pop        (q_pop),
    .q_item       (q_head),
    .min_level    (min_r),
    .max_level    (max_r),
    .ticks        (ticks_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ac_value (out_ac_value),
    .out_beat     (out_beat),
    .out_bpm      (out_bpm),
    .div_start    (bs),
    .div_num      (bn),
    .div_den      (bd),
    .div_done     (dd && !f_own_r),
    .div_quo      (dq),
    .div_busy     (b_busy)
  );

endmodule

FILE: sim/ppg_beat_and_rate_detector_tb.sv
`timescale 1ns / 1ps
module ppg_beat_and_rate_detector_tb;

  typedef enum logic [1:0] {TRK_IDLE = 2'd0, TRK_RISING = 2'd1, TRK_FALLING = 2'd2}
    trk_mode_t;

  typedef struct {
    logic signed [ppgbr_pkg::AC_W-1:0] ac;
    logic                              beat;
    logic [ppgbr_pkg::RATE_W-1:0]      bpm;
  } pulse_result_t;

  localparam int MEAN_N = 16;
  localparam int RATE_N = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  class pulse_scoreboard;
    pulse_result_t pending_q[$];
    int errors;
    int beats_seen;
    int checked;
    longint unsigned min_lvl, max_lvl, tpm;
    longint dc;
    int win[MEAN_N];
    int win_sum;
    int win_slot, win_fill;
    longint lp_prior, lp_latest;
    trk_mode_t mode;
    longint unsigned prev_lvl;
    logic [31:0] pk_time, prior_pk_time;
    logic [31:0] hist[RATE_N];
    int hist_slot, hist_fill;
    logic [31:0] avg_rate;

    function new();
      min_lvl = ppgbr_pkg::MIN_LEVEL_RST;
      max_lvl = ppgbr_pkg::MAX_LEVEL_RST;
      tpm = ppgbr_pkg::TICKS_RST;
      dc = 0;
      foreach (win[i]) win[i] = 0;
      win_sum = 0; win_slot = 0; win_fill = 0;
      lp_prior = 0; lp_latest = 0;
      mode = TRK_IDLE;
      prev_lvl = 0; pk_time = 0; prior_pk_time = 0;
      foreach (hist[i]) hist[i] = 0;
      hist_slot = 0; hist_fill = 0; avg_rate = 0;
      errors = 0; beats_seen = 0; checked = 0;
    endfunction

    function void write_reg(logic [ppgbr_pkg::IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        ppgbr_pkg::REG_MIN_LEVEL: min_lvl = data[ppgbr_pkg::LEVEL_W-1:0];
        ppgbr_pkg::REG_MAX_LEVEL: max_lvl = data[ppgbr_pkg::LEVEL_W-1:0];
        ppgbr_pkg::REG_TICKS:     tpm = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [ppgbr_pkg::SAMPLE_W-1:0] smp, logic [31:0] ts);
      longint old_dc, t, acc, s;
      int x, ac;
      logic [31:0] span, raw;
      longint unsigned total;
      pulse_result_t r;
      old_dc = dc;
      t = longint'(smp) * 100 + dc * 94;
      dc = t / 100;
      x = int'(dc - old_dc);
      win_sum = win_sum - win[win_slot] + x;
      win[win_slot] = x;
      win_slot = (win_slot + 1 >= MEAN_N) ? 0 : win_slot + 1;
      if (win_fill < MEAN_N) win_fill++;
      x = win_sum / win_fill - x;
      lp_prior = lp_latest;
      acc = longint'(ppgbr_pkg::LP_B) * longint'(x) * 256 +
            longint'(ppgbr_pkg::LP_A) * lp_prior;
      lp_latest = (acc + 8388608) >>> 24;
      s = (lp_prior + lp_latest) / 256;
      if (s > 8388607) s = 8388607;
      if (s < -8388608) s = -8388608;
      ac = int'(s);
      r.ac = ac[ppgbr_pkg::AC_W-1:0];
      r.beat = 1'b0;
      if (ac < 0 || longint'(ac) > longint'(max_lvl)) begin
        mode = TRK_IDLE;
        prev_lvl = 0; pk_time = 0; prior_pk_time = 0;
      end else begin
        if (mode == TRK_RISING && longint'(ac) <= longint'(prev_lvl)) begin
          span = pk_time - prior_pk_time;
          prior_pk_time = pk_time;
          raw = (span != 0) ? 32'(tpm / span) : 32'd0;
          hist[hist_slot] = raw;
          total = 0;
          foreach (hist[i]) total += hist[i];
          hist_slot = (hist_slot + 1 >= RATE_N) ? 0 : hist_slot + 1;
          if (hist_fill < RATE_N) hist_fill++;
          avg_rate = 32'(total / hist_fill);
          mode = TRK_FALLING;
          r.beat = 1'b1;
        end else begin
          if (mode == TRK_RISING) pk_time = ts;
          else if (mode == TRK_FALLING) begin
            if (ac < min_lvl) mode = TRK_IDLE;
          end else if (ac >= min_lvl) mode = TRK_RISING;
          prev_lvl = ac;
        end
      end
      r.bpm = avg_rate;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic signed [ppgbr_pkg::AC_W-1:0] ac, logic beat,
                               logic [31:0] bpm);
      pulse_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat out: ac=%0d beat=%0b bpm=%0d", ac, beat, bpm);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (beat) beats_seen++;
      if (ac !== e.ac || beat !== e.beat || bpm !== e.bpm) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp ac=%0d beat=%0b bpm=%0d, got ac=%0d beat=%0b bpm=%0d",
                   e.ac, e.beat, e.bpm, ac, beat, bpm);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ppgbr_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic [ppgbr_pkg::TS_W-1:0] in_timestamp = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ppgbr_pkg::AC_W-1:0] out_ac_value;
  logic out_beat;
  logic [ppgbr_pkg::RATE_W-1:0] out_bpm;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ppgbr_pkg::IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pulse_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_go = 1'b0;
  int hold_cnt = 0;
  logic hold_done = 1'b0;
  int quiet_cycles = 0;
  logic [31:0] ts_now;

  always #1 clk = ~clk;

  ppg_beat_and_rate_detector DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample(in_sample), .in_timestamp(in_timestamp),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ac_value(out_ac_value), .out_beat(out_beat), .out_bpm(out_bpm),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (hold_go && !hold_done && hold_cnt == 0) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_ac_value, out_beat, out_bpm);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n || hold_cnt > 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_sample(logic [ppgbr_pkg::SAMPLE_W-1:0] smp, logic [31:0] ts);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= smp;
    in_timestamp <= ts;
    do @(posedge clk); while (in_stall);
    sb.note_sample(smp, ts);
  endtask

  task automatic write_cfg(logic [ppgbr_pkg::IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_levels(logic [31:0] lo, logic [31:0] hi, logic [31:0] tpm);
    drain();
    write_cfg(ppgbr_pkg::REG_MIN_LEVEL, lo);
    write_cfg(ppgbr_pkg::REG_MAX_LEVEL, hi);
    write_cfg(ppgbr_pkg::REG_TICKS, tpm);
  endtask

  // pulse trains with random shape, plus some raw noise
  task automatic send_pulses(int count);
    int period, pos, amp, base, ramp;
    logic [31:0] smp;
    period = 0; pos = 0; amp = 0; base = 0;
    for (int n = 0; n < count; n++) begin
      if (pos >= period) begin
        period = $urandom_range(4, 40);
        pos = 0;
        amp = $urandom_range(0, 7) == 0 ? $urandom_range(0, 262143) : $urandom_range(0, 3000);
        base = $urandom_range(0, 262143 - amp);
      end
      ramp = (pos < period / 2) ? pos : period - pos;
      smp = base + amp * ramp * 2 / (period > 1 ? period : 1);
      if (smp > 262143) smp = 262143;
      if ($urandom_range(0, 9) == 0) smp = $urandom_range(0, 262143);
      case ($urandom_range(0, 19))
        0: ;
        1: ts_now = ts_now + $urandom;
        default: ts_now = ts_now + $urandom_range(1, 20);
      endcase
      send_sample(smp[ppgbr_pkg::SAMPLE_W-1:0], ts_now);
      pos++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_cfg(ppgbr_pkg::REG_MIN_LEVEL, 32'd100);
    write_cfg(ppgbr_pkg::REG_MAX_LEVEL, 32'd2000);
    write_cfg(ppgbr_pkg::REG_TICKS, 32'd60000000);

    send_sample('0, 32'd0);
    send_sample('1, 32'hFFFF_FFFF);
    send_sample('0, 32'hFFFF_FFFF);
    send_sample('1, 32'd0);
    for (int i = 0; i < 8; i++) send_sample(18'd1000 + i * 3000, 32'd100 + i);
    for (int i = 0; i < 8; i++) send_sample(18'd25000 - i * 3000, 32'd108);
    send_sample(18'h2AAAA, 32'hAAAA_AAAA);
    send_sample(18'h15555, 32'h5555_5555);

    tx_idle_pct = 28; rx_idle_pct = 52;
    ts_now = $urandom;
    send_pulses(400);
    set_levels(32'd0, 32'h7F_FFFF, 32'hFFFF_FFFF);
    send_pulses(200);

    tx_idle_pct = 52; rx_idle_pct = 28;
    set_levels(32'h7F_FFFF, 32'd0, 32'd1);
    send_pulses(100);
    set_levels(32'd0, 32'd0, 32'd0);
    send_pulses(100);
    set_levels($urandom_range(0, 300), $urandom_range(500, 20000), $urandom);
    send_pulses(300);

    tx_idle_pct = 0; rx_idle_pct = 0;
    set_levels(32'd50, 32'd5000, 32'd60000000);
    hold_go <= 1'b1;
    send_pulses(600);

    drain();
    $display("Checked %0d results with %0d beats across six register settings,",
             sb.checked, sb.beats_seen);
    $display("including a long output hold-off and both idle mixes.");
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
